FILE: src/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes of the complex integer ALU.
// Holds the command codes and the item carried from front to back.
// ----------------------------------------------------------------------------
package cia_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_MUL = 3'd1,
        CMD_DIV = 3'd2,
        CMD_POW = 3'd3,
        CMD_MAG = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] a_re;
        logic [31:0] a_im;
        logic [31:0] b_re;
        logic [31:0] b_im;
        logic [7:0]  exponent;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_POW,
        ST_POW2,
        ST_DIVP,
        ST_DIV,
        ST_SQ,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

FILE: src/complex_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// complex_integer_alu_unit: Gaussian integer arithmetic unit.
// Add, multiply, divide, power and magnitude on complex integers.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries a command, two complex operands
// and an exponent; the block returns exactly one master-side transaction per
// input, in order. Add and unknown commands need no further step, multiply
// takes one product step, divide forms the products and the divisor's norm
// and runs the restoring divider (one quotient bit per cycle; a zero divisor
// ends at the norm check), magnitude squares and takes the square root (two
// radicand bits per cycle), and power does one complex multiply per exponent
// step. One item is in execution at a time; the next one starts the
// cycle after the result has been taken, and a two-entry queue in front lets
// the sender run ahead. After reset the queue is empty and no result is
// pending. When the receiver stalls, the result is held in the output
// register and the back end takes no new item until it has gone; the queue
// then fills and s_axis_tready falls.
// ----------------------------------------------------------------------------
module complex_integer_alu_unit #(
    parameter int DATA_WIDTH    = 32,
    parameter int MAX_EXPONENT  = 255,
    parameter int MAG_FRAC_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_re, a_im, b_re, b_im, exponent from the lowest bit up
    input  logic [135:0] s_axis_tdata,
    // cmd
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_re, res_im, magnitude from the lowest bit up
    output logic [103:0] m_axis_tdata,
    // div_zero
    output logic         m_axis_tuser
);
    import cia_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;
    logic [31:0] res_re, res_im;
    logic [39:0] magnitude;

    // Unpack the slave-side payload into one queued item.
    assign in_item.cmd      = s_axis_tuser;
    assign in_item.a_re     = s_axis_tdata[31:0];
    assign in_item.a_im     = s_axis_tdata[63:32];
    assign in_item.b_re     = s_axis_tdata[95:64];
    assign in_item.b_im     = s_axis_tdata[127:96];
    assign in_item.exponent = s_axis_tdata[135:128];

    cia_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cia_back #(
        .DATA_WIDTH    (DATA_WIDTH),
        .MAX_EXPONENT  (MAX_EXPONENT),
        .MAG_FRAC_BITS (MAG_FRAC_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_re    (res_re),
        .res_im    (res_im),
        .magnitude (magnitude),
        .div_zero  (m_axis_tuser)
    );

    // The result register holds the payload steady while the receiver stalls.
    assign m_axis_tdata = {magnitude, res_im, res_re};

endmodule

FILE: src/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front: input stage and two-entry queue.
// Accepts input transactions and holds them until the back end takes them.
// ----------------------------------------------------------------------------
module cia_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cia_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output cia_pkg::item_t q_item
);
    import cia_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: src/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back: execution sequencer.
// Carries out one operation at a time with four shared multipliers, a
// restoring divider and a bit-serial square root.
// ----------------------------------------------------------------------------
module cia_back #(
    parameter int DATA_WIDTH    = 32,
    parameter int MAX_EXPONENT  = 255,
    parameter int MAG_FRAC_BITS = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  cia_pkg::item_t q_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    res_re,
    output logic [31:0]    res_im,
    output logic [39:0]    magnitude,
    output logic           div_zero
);
    import cia_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW + 1;               // sum of two products
    localparam int SW  = 2 * DW + 2 * MAG_FRAC_BITS + 2;
    localparam int RW  = SW / 2 + 1;
    localparam int SQN = SW / 2;
    localparam int EW  = (MAX_EXPONENT > 255) ? 8 : $clog2(MAX_EXPONENT + 1);
    localparam logic [7:0] EMAX = (MAX_EXPONENT > 255) ? 8'd255 : 8'(MAX_EXPONENT);

    state_t state_reg, state_next;

    logic [2:0]           cmd_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [DW-1:0] zr_reg, zi_reg;
    logic [EW-1:0]        ecnt_reg;
    logic [7:0]           cnt_reg;
    logic signed [2*DW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [PW-1:0]        num_r_reg, num_i_reg, den_reg, rem_r_reg, rem_i_reg;
    logic                 neg_r_reg, neg_i_reg;
    logic [SW-1:0]        sq_reg, srem_reg;
    logic [RW-1:0]        root_reg;
    logic [31:0]          ores_re_reg, ores_im_reg;
    logic [39:0]          omag_reg;
    logic                 odz_reg, ovalid_reg;

    // Multiplier operands chosen by state.
    logic signed [DW-1:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
    always_comb
    begin
        m0a = ar_reg; m0b = br_reg; m1a = ai_reg; m1b = bi_reg;
        m2a = ar_reg; m2b = bi_reg; m3a = ai_reg; m3b = br_reg;
        case (state_reg)
            ST_POW:
            begin
                m0a = zr_reg; m0b = ar_reg; m1a = zi_reg; m1b = ai_reg;
                m2a = zr_reg; m2b = ai_reg; m3a = zi_reg; m3b = ar_reg;
            end
            ST_MUL2:
            begin
                m0a = br_reg; m0b = br_reg; m1a = bi_reg; m1b = bi_reg;
                m2a = ar_reg; m2b = ar_reg; m3a = ai_reg; m3b = ai_reg;
            end
            default: ;
        endcase
    end

    logic signed [2*DW-1:0] p0, p1, p2, p3;
    assign p0 = m0a * m0b;
    assign p1 = m1a * m1b;
    assign p2 = m2a * m2b;
    assign p3 = m3a * m3b;

    // Exact signed sums of the products.
    logic signed [PW-1:0] sden, ssq;
    assign sden = PW'(p0_reg) + PW'(p1_reg);
    assign ssq  = PW'(p2_reg) + PW'(p3_reg);

    // Restoring divide step, one quotient bit per cycle for both parts.
    logic [PW:0] tr, ti;
    assign tr = {rem_r_reg, num_r_reg[PW-1]} - {1'b0, den_reg};
    assign ti = {rem_i_reg, num_i_reg[PW-1]} - {1'b0, den_reg};

    // Square root step, two radicand bits per cycle.
    logic [RW+1:0] sq_trial, sq_pair;
    logic [RW+1:0] sq_rem2;
    assign sq_pair  = {srem_reg[RW-1:0], sq_reg[SW-1:SW-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_rem2  = sq_pair - sq_trial;

    function automatic logic [31:0] wrap(input logic [PW-1:0] v);
        logic [DW-1:0] t;
        t = v[DW-1:0];
        return 32'($signed(t));
    endfunction

    assign q_ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign res_re    = ores_re_reg;
    assign res_im    = ores_im_reg;
    assign magnitude = omag_reg;
    assign div_zero  = odz_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid && !ovalid_reg)
                begin
                    case (q_item.cmd)
                        CMD_MUL: state_next = ST_MUL1;
                        CMD_DIV: state_next = ST_MUL1;
                        CMD_POW: state_next = ST_POW2;
                        CMD_MAG: state_next = ST_MUL2;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_MUL1:  state_next = (cmd_reg == CMD_DIV) ? ST_MUL2 : ST_DONE;
            ST_MUL2:  state_next = (cmd_reg == CMD_MAG) ? ST_SQ : ST_DIVP;
            ST_DIVP:  state_next = (sden == '0) ? ST_DONE : ST_DIV;
            ST_DIV:   state_next = (cnt_reg == 8'(PW - 1)) ? ST_DONE : ST_DIV;
            ST_SQ:    state_next = ST_SQRT;
            ST_SQRT:  state_next = (cnt_reg == 8'(SQN - 1)) ? ST_DONE : ST_SQRT;
            ST_POW2:  state_next = (ecnt_reg == '0) ? ST_DONE : ST_POW;
            ST_POW:   state_next = ST_POW2;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                // Load only on acceptance so a waiting result stays intact.
                if (q_valid && !ovalid_reg)
                begin
                    cmd_reg <= q_item.cmd;
                    ar_reg  <= q_item.a_re[DW-1:0];
                    ai_reg  <= q_item.a_im[DW-1:0];
                    br_reg  <= q_item.b_re[DW-1:0];
                    bi_reg  <= q_item.b_im[DW-1:0];
                    zr_reg  <= DW'(1);
                    zi_reg  <= '0;
                    ecnt_reg <= EW'((q_item.exponent > EMAX) ? EMAX : q_item.exponent);
                    cnt_reg <= '0;
                    odz_reg <= 1'b0;
                    omag_reg <= '0;
                    if (q_item.cmd > 3'(CMD_POW))
                    begin
                        ores_re_reg <= '0;
                        ores_im_reg <= '0;
                    end
                    else
                    begin
                        ores_re_reg <= wrap(PW'(q_item.a_re[DW-1:0] + q_item.b_re[DW-1:0]));
                        ores_im_reg <= wrap(PW'(q_item.a_im[DW-1:0] + q_item.b_im[DW-1:0]));
                    end
                end
            end
            ST_MUL1:
            begin
                p0_reg <= p0; p1_reg <= p1; p2_reg <= p2; p3_reg <= p3;
                ores_re_reg <= wrap(PW'(p0) - PW'(p1));
                ores_im_reg <= wrap(PW'(p2) + PW'(p3));
                num_r_reg <= PW'(p0) + PW'(p1);
                num_i_reg <= PW'(p3) - PW'(p2);
            end
            ST_MUL2:
            begin
                p0_reg <= p0; p1_reg <= p1; p2_reg <= p2; p3_reg <= p3;
                neg_r_reg <= num_r_reg[PW-1];
                neg_i_reg <= num_i_reg[PW-1];
                num_r_reg <= num_r_reg[PW-1] ? -num_r_reg : num_r_reg;
                num_i_reg <= num_i_reg[PW-1] ? -num_i_reg : num_i_reg;
            end
            ST_DIVP:
            begin
                den_reg   <= sden;
                rem_r_reg <= '0;
                rem_i_reg <= '0;
                if (sden == '0)
                begin
                    odz_reg     <= 1'b1;
                    ores_re_reg <= '0;
                    ores_im_reg <= '0;
                end
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 8'd1;
                num_r_reg <= {num_r_reg[PW-2:0], ~tr[PW]};
                num_i_reg <= {num_i_reg[PW-2:0], ~ti[PW]};
                rem_r_reg <= tr[PW] ? {rem_r_reg[PW-2:0], num_r_reg[PW-1]} : tr[PW-1:0];
                rem_i_reg <= ti[PW] ? {rem_i_reg[PW-2:0], num_i_reg[PW-1]} : ti[PW-1:0];
                if (cnt_reg == 8'(PW - 1))
                begin
                    ores_re_reg <= wrap(neg_r_reg ? -{num_r_reg[PW-2:0], ~tr[PW]}
                                                  : {num_r_reg[PW-2:0], ~tr[PW]});
                    ores_im_reg <= wrap(neg_i_reg ? -{num_i_reg[PW-2:0], ~ti[PW]}
                                                  : {num_i_reg[PW-2:0], ~ti[PW]});
                end
            end
            ST_SQ:
            begin
                sq_reg   <= SW'(ssq) << (2 * MAG_FRAC_BITS);
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                cnt_reg <= cnt_reg + 8'd1;
                sq_reg  <= sq_reg << 2;
                if (!sq_rem2[RW+1])
                begin
                    srem_reg <= SW'(sq_rem2);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                    omag_reg <= 40'({root_reg[RW-2:0], 1'b1});
                end
                else
                begin
                    srem_reg <= SW'(sq_pair);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                    omag_reg <= 40'({root_reg[RW-2:0], 1'b0});
                end
            end
            ST_POW:
            begin
                zr_reg <= DW'(p0 - p1);
                zi_reg <= DW'(p2 + p3);
                ecnt_reg <= ecnt_reg - EW'(1);
            end
            ST_POW2:
            begin
                ores_re_reg <= 32'(zr_reg);
                ores_im_reg <= 32'(zi_reg);
            end
            default: ;
        endcase
    end

endmodule

FILE: src/cia_checker.sv
// ----------------------------------------------------------------------------
// cia_checker: port-level checks of the complex integer ALU.
// Watches the output channel and the divide-by-zero flag over time.
// ----------------------------------------------------------------------------
module cia_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A divide-by-zero result has zero parts and zero magnitude.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("divide by zero with nonzero result");

    // Results never come back to back: valid drops after each accepted result.
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("results back to back");

endmodule

bind complex_integer_alu_unit cia_checker u_cia_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_complex_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_integer_alu_unit: self-checking bench for the complex ALU.
// Drives directed and random transactions through the slave stream, predicts
// every result in the bench and compares each master-side transaction with
// the oldest prediction, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_complex_integer_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    // Generous ceiling on the run, in clock cycles.
    localparam int CYCLE_LIMIT = 4000000;

    // One predicted result, field by field.
    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic [39:0] mag;
        logic        dz;
    } alu_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // a_re, a_im, b_re, b_im, exponent from the lowest bit up
    logic [135:0] s_axis_tdata = '0;
    // cmd
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // res_re, res_im, magnitude from the lowest bit up
    logic [103:0] m_axis_tdata;
    // div_zero
    logic         m_axis_tuser;

    alu_result_t pending_results[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    complex_integer_alu_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // The cycle counter doubles as the watchdog for a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Computes the expected result of one operation. Wide signed arithmetic
    // keeps the divide and magnitude exact before truncation.
    function automatic alu_result_t compute_result(input logic [2:0] op,
            input logic [31:0] ar, input logic [31:0] ai,
            input logic [31:0] br, input logic [31:0] bi,
            input logic [7:0] e);
        logic signed [127:0] xr, xi, yr, yi, nr, ni, den, q;
        logic [31:0]         pr, pi, tr;
        logic [79:0]         rad, root, trial;
        alu_result_t         r;
        r = '0;
        xr = $signed(ar);
        xi = $signed(ai);
        yr = $signed(br);
        yi = $signed(bi);
        case (op)
            CMD_ADD:
            begin
                r.re = ar + br;
                r.im = ai + bi;
            end
            CMD_MUL:
            begin
                r.re = ar * br - ai * bi;
                r.im = ar * bi + ai * br;
            end
            CMD_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    // a * conj(b), each part truncated toward zero.
                    nr = xr * yr + xi * yi;
                    ni = xi * yr - xr * yi;
                    q = nr / den;
                    r.re = q[31:0];
                    q = ni / den;
                    r.im = q[31:0];
                end
            end
            CMD_POW:
            begin
                pr = 32'd1;
                pi = 32'd0;
                for (int k = 0; k < e; k++)
                begin
                    tr = pr * ar - pi * ai;
                    pi = pr * ai + pi * ar;
                    pr = tr;
                end
                r.re = pr;
                r.im = pi;
            end
            CMD_MAG:
            begin
                // floor(|a| * 256) equals the integer root of |a|^2 * 2^16.
                rad = 80'(xr * xr + xi * xi) << 16;
                root = '0;
                for (int k = 39; k >= 0; k--)
                begin
                    trial = root | (80'd1 << k);
                    if (trial * trial <= rad)
                        root = trial;
                end
                r.mag = root[39:0];
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Sends one transaction, with random idle cycles in front of it.
    task automatic send_item(input logic [2:0] op, input logic [31:0] ar,
            input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
            input logic [7:0] e);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {e, bi, br, ai, ar};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(compute_result(op, ar, ai, br, bi, e));
        sent_count++;
    endtask

    // Lowers valid once the last transaction has been taken.
    task automatic release_bus();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // The receiver stalls at random by the current percentage.
    always @(negedge clk)
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);

    // Each accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction with nothing pending");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (m_axis_tdata[31:0] !== want.re)
                begin
                    $error("res_re: expected %h, got %h", want.re, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.im)
                begin
                    $error("res_im: expected %h, got %h", want.im, m_axis_tdata[63:32]);
                    error_count++;
                end
                if (m_axis_tdata[103:64] !== want.mag)
                begin
                    $error("magnitude: expected %h, got %h", want.mag,
                           m_axis_tdata[103:64]);
                    error_count++;
                end
                if (m_axis_tuser !== want.dz)
                begin
                    $error("div_zero: expected %b, got %b", want.dz, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Picks an operand part: mostly full range, some small, some extremes.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(8)) - 4);
            3, 4: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // Waits until every predicted result has come back.
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff, 8'd0);
        send_item(CMD_ADD, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0, 8'hff);
        // Scalar add: only the real part moves.
        send_item(CMD_ADD, 32'd5, 32'd9, 32'd100, 32'd0, 8'd0);
        send_item(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 8'd0);
        send_item(CMD_MUL, 32'd3, 32'd4, 32'hffff_fffe, 32'd7, 8'd0);
        // Divide by zero gives zero parts and the flag.
        send_item(CMD_DIV, 32'd17, 32'd3, 32'd0, 32'd0, 8'd0);
        send_item(CMD_DIV, 32'd7, 32'hffff_fff9, 32'd2, 32'd3, 8'd0);
        send_item(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 8'd0);
        send_item(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff, 8'd0);
        send_item(CMD_DIV, 32'hffff_fffb, 32'd0, 32'd2, 32'd0, 8'd0);
        // Power: zero exponent, one, and the largest.
        send_item(CMD_POW, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0);
        send_item(CMD_POW, 32'd3, 32'hffff_fffe, 32'd0, 32'd0, 8'd1);
        send_item(CMD_POW, 32'd1, 32'd1, 32'd0, 32'd0, 8'd255);
        send_item(CMD_POW, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, 8'd128);
        send_item(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 8'd0);
        send_item(CMD_MAG, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0);
        send_item(CMD_MAG, 32'd3, 32'hffff_fffc, 32'd0, 32'd0, 8'd0);
        send_item(CMD_MAG, 32'd1, 32'd1, 32'd0, 32'd0, 8'd0);
        // Unknown commands return all zeros.
        send_item(3'd5, 32'd1, 32'd2, 32'd3, 32'd4, 8'd5);
        send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 8'hff);
        release_bus();
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [2:0]  op;
        logic [31:0] br, bi;
        logic [7:0]  e;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4));
            br = pick_part();
            bi = pick_part();
            if ($urandom_range(9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            // Mostly short powers keep the run short; a few reach deep.
            e = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(12));
            send_item(op, pick_part(), pick_part(), br, bi, e);
        end
        release_bus();
    endtask

    // The sender holds off until the block has returned everything.
    task automatic test_drain_pause();
        test_random(20, 0, 0);
        wait_drained();
        repeat (10) @(posedge clk);
        test_random(20, 0, 0);
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(470, 0, 0);
        test_drain_pause();
        test_random(470, 77, 0);
        test_random(470, 0, 77);
        test_random(470, 36, 36);

        wait_drained();
        repeat (600) @(posedge clk);
        $display("Ran %0d transactions, %0d results checked, across all operations",
                 sent_count, checked_count);
        $display("under free-running, idle-sender, stalled-receiver and mixed phases.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
